### rtl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg: shared definitions of the generational handle table
// Field widths, operation codes and the control structs passed between the
// execute logic and the free-index stack.
// ----------------------------------------------------------------------------
package ght_pkg;

	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned GEN_W    = 10;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned HANDLE_W = INDEX_W + GEN_W;
	localparam int unsigned DEPTH    = 1 << INDEX_W;

	localparam logic [GEN_W-1:0]   GEN_RESET  = GEN_W'(1);
	localparam logic [INDEX_W-1:0] INDEX_MASK = {INDEX_W{1'b1}};

	// operation codes
	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// command from the execute logic to the free stack
	typedef struct packed {
		logic               push;
		logic               pop;
		logic [INDEX_W-1:0] data;
	} stk_cmd_t;

	// status from the free stack to the execute logic
	typedef struct packed {
		logic               empty;
		logic [INDEX_W-1:0] top;
	} stk_stat_t;

endpackage

### rtl/ght_if.sv
// ----------------------------------------------------------------------------
// ght_if: request and response channels of the generational handle table
// Valid/ready channels; a transfer happens on a rising edge with both high.
// ----------------------------------------------------------------------------
interface ght_req_if import ght_pkg::*;;
	logic                valid;
	logic                ready;
	logic [1:0]          op;
	logic [VALUE_W-1:0]  stored_value;
	logic [HANDLE_W-1:0] handle_in;

	modport source (output valid, output op, output stored_value, output handle_in,
		input ready);
	modport sink (input valid, input op, input stored_value, input handle_in,
		output ready);
endinterface

interface ght_rsp_if import ght_pkg::*;;
	logic                valid;
	logic                ready;
	logic [HANDLE_W-1:0] handle_out;
	logic [VALUE_W-1:0]  value_out;
	logic                success;

	modport source (output valid, output handle_out, output value_out, output success,
		input ready);
	modport sink (input valid, input handle_out, input value_out, input success,
		output ready);
endinterface

### rtl/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered and returns the
// old contents when the same address is written on the same edge.
// ----------------------------------------------------------------------------
module ght_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AddrW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/ght_free_stack.sv
// ----------------------------------------------------------------------------
// ght_free_stack: LIFO of freed indexes
// The top entry lives in a register; the memory is read every cycle at the
// slot just below the next top, so a pop in any cycle has its new top ready.
// ----------------------------------------------------------------------------
module ght_free_stack import ght_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  stk_cmd_t  cmd,
	output stk_stat_t stat
);

	logic [INDEX_W-1:0] cnt_q;
	logic [INDEX_W-1:0] cnt_next;
	logic [INDEX_W-1:0] top_q;
	logic [INDEX_W-1:0] under;
	logic               full;
	logic               do_push;

	assign full    = &cnt_q;
	assign do_push = cmd.push && !full;

	// next fill count
	always_comb begin
		cnt_next = cnt_q;
		if (do_push) begin
			cnt_next = cnt_q + INDEX_W'(1);
		end else if (cmd.pop) begin
			cnt_next = cnt_q - INDEX_W'(1);
		end
	end

	// hold the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

	// advance the top register
	always_ff @(posedge clk) begin
		if (do_push) begin
			top_q <= cmd.data;
		end else if (cmd.pop) begin
			top_q <= under;
		end
	end

	ght_ram #(
		.WIDTH (INDEX_W),
		.DEPTH (DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (cnt_q),
		.wdata (cmd.data),
		.re    (1'b1),
		.raddr (cnt_next - INDEX_W'(2)),
		.rdata (under)
	);

	assign stat.empty = (cnt_q == '0);
	assign stat.top   = top_q;

endmodule

### rtl/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table: handle allocator with generation check
// Issues generation:index handles for stored values, frees them and looks
// them up; freed indexes are reused last-in first-out.
// ----------------------------------------------------------------------------
// Takes one request per clock while the response side does not stall, and
// returns one response per request, in order. A request is registered with
// the entry memory read at its index; execute then decides the operation,
// writes the entry memory and the free stack, and loads the response
// register. Back-to-back requests to the same index see each other through a
// one-deep write bypass, and the free stack keeps its top in a register with
// the entry below it read ahead, so the single execute stage sets the rate of
// one request per cycle. Entries (1024 x 32) and the free stack (1024 x 10)
// are memories with no clearing pass; the generation register resets to 1 and
// may be written only while no request is in flight.
module generational_handle_table import ght_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [GEN_W-1:0] cfg_wdata,
	ght_req_if.sink          req,
	ght_rsp_if.source        rsp
);

	// configuration and table state
	logic [GEN_W-1:0]   gen_q;
	logic [INDEX_W-1:0] ext_q;

	// execute stage
	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [VALUE_W-1:0] val_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic [GEN_W-1:0]   hgen_s1;
	logic               fwd_hit_s1;
	logic [VALUE_W-1:0] fwd_data_s1;

	// response register
	logic                out_valid_q;
	logic [HANDLE_W-1:0] hout_q;
	logic [VALUE_W-1:0]  vout_q;
	logic                ok_q;

	logic               accept;
	logic               exec;
	logic [INDEX_W-1:0] idx_in;
	logic [VALUE_W-1:0] ent_rdata;
	logic [VALUE_W-1:0] entry;
	logic               in_range;

	logic               ent_we;
	logic [INDEX_W-1:0] ent_waddr;
	logic [VALUE_W-1:0] ent_wdata;
	logic               ext_inc;

	logic [HANDLE_W-1:0] hout;
	logic [VALUE_W-1:0]  vout;
	logic                ok;

	stk_cmd_t  stk_cmd;
	stk_stat_t stk_stat;

	assign exec      = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || exec;
	assign accept    = req.valid && req.ready;
	assign idx_in    = req.handle_in[INDEX_W-1:0];

	// hold the generation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= GEN_RESET;
		end else if (cfg_we) begin
			gen_q <= cfg_wdata;
		end
	end

	// pick the entry value, bypassing a write made on the read edge
	assign entry    = fwd_hit_s1 ? fwd_data_s1 : ent_rdata;
	assign in_range = idx_s1 < ext_q;

	// decide the operation
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = idx_s1;
		ent_wdata = '0;
		ext_inc   = 1'b0;
		stk_cmd   = '{push: 1'b0, pop: 1'b0, data: idx_s1};
		hout      = '0;
		vout      = '0;
		ok        = 1'b0;
		unique case (op_s1)
			OP_ALLOC: begin
				if (!stk_stat.empty) begin
					stk_cmd.pop = exec;
					ent_waddr   = stk_stat.top;
					ok          = 1'b1;
				end else if (ext_q != INDEX_MASK) begin
					ext_inc   = exec;
					ent_waddr = ext_q;
					ok        = 1'b1;
				end
				ent_we    = exec && ok;
				ent_wdata = val_s1;
				hout      = ok ? {gen_q, ent_waddr} : '0;
			end
			OP_REMOVE: begin
				if (in_range && entry != '0) begin
					ok           = 1'b1;
					ent_we       = exec;
					stk_cmd.push = exec;
				end
			end
			OP_LOOKUP: begin
				if (hgen_s1 == gen_q && in_range) begin
					vout = entry;
					ok   = (entry != '0);
				end
			end
			default: begin
			end
		endcase
	end

	// advance the used extent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= '0;
		end else if (ext_inc) begin
			ext_q <= ext_q + INDEX_W'(1);
		end
	end

	// hold the execute-stage valid and bypass flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1   <= req.valid;
			fwd_hit_s1 <= ent_we && (ent_waddr == idx_in);
		end
	end

	// capture the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= req.op;
			val_s1      <= req.stored_value;
			idx_s1      <= idx_in;
			hgen_s1     <= req.handle_in[HANDLE_W-1:INDEX_W];
			fwd_data_s1 <= ent_wdata;
		end
	end

	ght_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (accept),
		.raddr (idx_in),
		.rdata (ent_rdata)
	);

	ght_free_stack u_free_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.stat   (stk_stat)
	);

	// hold the response until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || rsp.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// load the response payload
	always_ff @(posedge clk) begin
		if (exec) begin
			hout_q <= hout;
			vout_q <= vout;
			ok_q   <= ok;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.handle_out = hout_q;
	assign rsp.value_out  = vout_q;
	assign rsp.success    = ok_q;

endmodule

### bench/generational_handle_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generational_handle_table_tb: self-checking bench of the handle table
// Drives allocate, remove and lookup requests over the valid/ready request
// channel. A scoreboard class keeps its own copy of the entries, the free
// stack, the extent and the generation. It predicts each reply when the
// request transfers and compares every reply, in order, field by field.
// Runs directed corners first, then random traffic under several generations,
// a long reply stall, and a burst of allocations.
// ----------------------------------------------------------------------------
module generational_handle_table_tb;
	import ght_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned PCT_IDLE = 14;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [VALUE_W-1:0]  value;
		logic                success;
	} reply_t;

	// shadow of the table state plus the queue of replies still owed
	class ght_scoreboard;
		logic [VALUE_W-1:0] entries [DEPTH];
		logic [INDEX_W-1:0] free_stack [DEPTH];
		logic [INDEX_W-1:0] free_count;
		logic [INDEX_W-1:0] used_extent;
		logic [GEN_W-1:0]   generation;
		reply_t             replies [$];
		int unsigned        errors;

		function new();
			free_count  = '0;
			used_extent = '0;
			generation  = GEN_RESET;
			errors      = 0;
		endfunction

		task report(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// apply one transferred request and queue the reply it owes
		function reply_t note_request(input logic [1:0] op, input logic [VALUE_W-1:0] val,
				input logic [HANDLE_W-1:0] h);
			reply_t             r;
			logic [INDEX_W-1:0] idx;
			logic [GEN_W-1:0]   hgen;
			logic [INDEX_W-1:0] slot;
			bit                 have;
			r    = '0;
			idx  = h[INDEX_W-1:0];
			hgen = h[HANDLE_W-1:INDEX_W];
			slot = '0;
			have = 0;
			case (op)
				OP_ALLOC: begin
					// reuse the last freed index, else take a fresh one
					if (free_count != 0) begin
						free_count--;
						slot = free_stack[free_count];
						have = 1;
					end else if (used_extent != INDEX_MASK) begin
						slot = used_extent;
						used_extent++;
						have = 1;
					end
					if (have) begin
						entries[slot] = val;
						r.handle  = {generation, slot};
						r.success = 1'b1;
					end
				end
				OP_REMOVE: begin
					// generation is ignored; only live nonzero entries free
					if (idx < used_extent && entries[idx] != 0) begin
						entries[idx] = '0;
						if (free_count < DEPTH - 1) begin
							free_stack[free_count] = idx;
							free_count++;
						end
						r.success = 1'b1;
					end
				end
				OP_LOOKUP: begin
					if (hgen == generation && idx < used_extent) begin
						r.value   = entries[idx];
						r.success = (r.value != 0);
					end
				end
				default: ;
			endcase
			replies.push_back(r);
			return r;
		endfunction

		// compare one reply against the oldest owed one
		task check_reply(input reply_t got);
			reply_t exp;
			if (replies.size() == 0) begin
				report($sformatf("unexpected reply h=%h v=%h s=%b",
					got.handle, got.value, got.success));
			end else begin
				exp = replies.pop_front();
				if (got.handle !== exp.handle)
					report($sformatf("handle_out %h, want %h", got.handle, exp.handle));
				if (got.value !== exp.value)
					report($sformatf("value_out %h, want %h", got.value, exp.value));
				if (got.success !== exp.success)
					report($sformatf("success %b, want %b", got.success, exp.success));
			end
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [GEN_W-1:0] cfg_wdata;

	ght_req_if req_ch();
	ght_rsp_if rsp_ch();

	generational_handle_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source)
	);

	ght_scoreboard       sb;
	bit                  quiet;
	int unsigned         rsp_hold;
	logic [HANDLE_W-1:0] issued [$];

	always #1 clk = ~clk;

	// offer one request, hold it until it transfers, then maybe idle
	task automatic send_req(input logic [1:0] op, input logic [VALUE_W-1:0] val,
			input logic [HANDLE_W-1:0] h, output reply_t rep);
		req_ch.valid        <= 1'b1;
		req_ch.op           <= op;
		req_ch.stored_value <= val;
		req_ch.handle_in    <= h;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		rep = sb.note_request(op, val, h);
		if (op == OP_ALLOC && rep.success) begin
			issued.push_back(rep.handle);
			if (issued.size() > 64)
				void'(issued.pop_front());
		end
		if (!quiet && $urandom_range(99) < PCT_IDLE) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send(input logic [1:0] op, input logic [VALUE_W-1:0] val,
			input logic [HANDLE_W-1:0] h);
		reply_t rep;
		send_req(op, val, h, rep);
	endtask

	// random request, mostly aimed at handles that were issued
	task automatic send_random();
		logic [1:0]          op;
		logic [VALUE_W-1:0]  val;
		logic [HANDLE_W-1:0] h;
		int unsigned         r;
		r = $urandom_range(99);
		if (r < 38)
			op = OP_ALLOC;
		else if (r < 62)
			op = OP_REMOVE;
		else if (r < 95)
			op = OP_LOOKUP;
		else
			op = OP_UNUSED;
		r = $urandom_range(99);
		if (r < 8)
			val = '0;
		else if (r < 12)
			val = '1;
		else
			val = VALUE_W'($urandom);
		r = $urandom_range(99);
		if (r < 60 && issued.size() > 0) begin
			h = issued[$urandom_range(0, issued.size() - 1)];
			if ($urandom_range(9) == 0)
				h[HANDLE_W-1:INDEX_W] = GEN_W'($urandom);
		end else if (r < 80) begin
			h = {sb.generation, INDEX_W'($urandom_range(0, sb.used_extent + 1))};
		end else begin
			h = HANDLE_W'($urandom);
		end
		send(op, val, h);
	endtask

	// drop valid and wait until every owed reply has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.replies.size() != 0) @(posedge clk);
	endtask

	// write the generation register with the block idle
	task automatic write_generation(input logic [GEN_W-1:0] g);
		drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.generation = g;
	endtask

	// reply side: sample transfers, then choose ready for the next cycle
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				sb.check_reply('{rsp_ch.handle_out, rsp_ch.value_out, rsp_ch.success});
			if (rsp_hold != 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold--;
			end else if (quiet) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= PCT_IDLE);
			end
		end
	end

	// request side and phase sequencing
	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.op           = OP_ALLOC;
		req_ch.stored_value = '0;
		req_ch.handle_in    = '0;
		quiet               = 1'b1;
		rsp_hold            = 0;
		sb                  = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, back to back, under the reset generation
		send(OP_LOOKUP, '0, {GEN_RESET, 10'd0});
		send(OP_REMOVE, '0, {GEN_RESET, 10'd0});
		send(OP_ALLOC, '1, '0);
		send(OP_ALLOC, '0, '0);
		send(OP_ALLOC, 32'd1, '1);
		send(OP_LOOKUP, '0, {GEN_RESET, 10'd0});
		send(OP_LOOKUP, '0, {GEN_RESET, 10'd1});
		send(OP_REMOVE, '0, {GEN_RESET, 10'd1});
		send(OP_LOOKUP, '0, {10'd0, 10'd0});
		send(OP_LOOKUP, '0, {GEN_RESET, 10'd5});
		send(OP_REMOVE, '0, {10'h3ff, 10'd2});
		send(OP_LOOKUP, '0, {GEN_RESET, 10'd2});
		send(OP_ALLOC, 32'h5a5a_5a5a, '0);
		send(OP_LOOKUP, '0, {GEN_RESET, 10'd2});
		send(OP_UNUSED, '1, '1);
		send(OP_REMOVE, '1, {GEN_RESET, INDEX_MASK});
		send(OP_LOOKUP, '1, '1);
		send(OP_REMOVE, '0, {GEN_RESET, 10'd0});
		send(OP_REMOVE, '0, {GEN_RESET, 10'd2});
		send(OP_ALLOC, 32'ha5a5_0001, '0);
		send(OP_ALLOC, 32'h8000_0000, '0);
		send(OP_LOOKUP, '0, {GEN_RESET, 10'd0});

		// generation change: old handles miss on lookup but still remove
		write_generation('0);
		send(OP_LOOKUP, '0, {GEN_RESET, 10'd0});
		send(OP_REMOVE, '0, {GEN_RESET, 10'd0});
		send(OP_ALLOC, 32'h0000_ffff, '0);

		// random traffic with idling on both sides
		quiet = 1'b0;
		write_generation(GEN_W'($urandom));
		repeat (200) send_random();

		// stretch with no idling at all
		quiet = 1'b1;
		repeat (100) send_random();

		// hold replies off long enough to back up the request side
		rsp_hold = 300;
		repeat (40) send_random();
		quiet = 1'b0;
		drain();

		write_generation('1);
		repeat (100) send_random();

		// burst of allocations to push the extent and drain the free stack
		drain();
		repeat (60) send(OP_ALLOC, VALUE_W'($urandom) | 32'd1, '0);
		repeat (30) send_random();

		write_generation('0);
		repeat (40) send_random();

		drain();
		repeat (10) @(posedge clk);
		if (sb.replies.size() != 0)
			sb.report($sformatf("%0d replies never arrived", sb.replies.size()));
		if (sb.errors == 0)
			$display("generational_handle_table_tb: clean");
		else
			$display("generational_handle_table_tb: errors");
		$finish;
	end

	// stop a hung run
	initial begin
		#400000;
		$display("generational_handle_table_tb: errors");
		$finish;
	end

endmodule
